[hw/rtl/wbrm_pkg.sv]
// wbrm_pkg: shared types and codes for the windowed byte rate meter.
// No dependencies; imported by windowed_byte_rate_meter.
package wbrm_pkg;

    // request codes carried on the req_type field
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE     = 9'b0_0000_0001,
        S_DIV      = 9'b0_0000_0010,
        S_ADD_RD   = 9'b0_0000_0100,
        S_ADD_WR   = 9'b0_0000_1000,
        S_SCAN_RD  = 9'b0_0001_0000,
        S_SCAN_ACC = 9'b0_0010_0000,
        S_SPAN     = 9'b0_0100_0000,
        S_FIN      = 9'b0_1000_0000,
        S_MOD      = 9'b1_0000_0000
    } t_state;

endpackage

[hw/rtl/wbrm_ram.sv]
// wbrm_ram: generic simple dual-port RAM, one write port and one registered read port.
// No dependencies; instantiated by windowed_byte_rate_meter.
module wbrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/windowed_byte_rate_meter.sv]
// windowed_byte_rate_meter: per-second byte buckets and windowed rate query.
// Depends on wbrm_pkg (types, codes) and wbrm_ram (bucket time and byte stores).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request beat: an add
//   (req_type 0) adds byte_count to the bucket of second now_seconds, a query
//   (req_type 1) returns the average bytes per second over the buckets of the
//   last WINDOW_SECONDS seconds, excluding the current one.
//   Output channel (o_out_valid / i_out_stall) returns exactly one beat per
//   request: new_second for an add, rate_bytes_per_sec for a query.
//   One request is in work at a time; o_in_stall is high while it runs.
//   Add: slot index (now mod SLOT_COUNT) from a reciprocal multiply taken at
//   accept plus a narrow subtract, then a bucket read and a bucket write.
//   Query: a bit-serial restoring divider, one quotient bit per cycle over
//   DW = 32 + clog2(WINDOW_SECONDS+1) bits, divides the window total by the span.
//   The slot walk reads every bucket in turn through the registered read and
//   then adds it; a zero span skips the divider and returns a rate of 0.
//   The next request is taken once the result is registered, as the sequencer
//   returns to idle on the same edge that loads the output register.
//   The result sits in an output register, so a stalled receiver only holds
//   the next result back at its final step.
//   Reset (synchronous, active low) clears all bucket valid bits and the
//   output valid; bucket RAM contents need no clearing.
module windowed_byte_rate_meter
    import wbrm_pkg::*;
#(
    parameter int SLOT_COUNT     = 10,
    parameter int WINDOW_SECONDS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_now_seconds,
    input  logic [15:0] i_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_new_second,
    output logic [31:0] o_rate_bytes_per_sec
);

    localparam int AW      = $clog2(SLOT_COUNT);
    localparam int AGE_W   = $clog2(WINDOW_SECONDS + 1);
    localparam int DW      = 32 + AGE_W;
    localparam int DIV_MAX = WINDOW_SECONDS;
    localparam int RW      = $clog2(DIV_MAX);
    localparam int RW1     = RW + 1;
    localparam int D_W     = $clog2(DIV_MAX + 1);
    localparam int CNT_W   = $clog2(DW + 1);
    // reciprocal of SLOT_COUNT, exact floor quotient for any 32-bit second
    localparam int MOD_SH  = 32 + AW;
    localparam logic [32:0] MOD_MUL =
        33'(((64'd1 << MOD_SH) + 64'(SLOT_COUNT - 1)) / 64'(SLOT_COUNT));

    t_state            r_state, n_state;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_qlo, n_qlo;
    logic [31:0]       r_now, n_now;
    logic [15:0]       r_bytes, n_bytes;
    logic [DW-1:0]     r_dvd, n_dvd;
    logic [RW-1:0]     r_rem, n_rem;
    logic [D_W-1:0]    r_dvs, n_dvs;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DW-1:0]     r_total, n_total;
    logic [AGE_W-1:0]  r_age, n_age;
    logic              r_res_new, n_res_new;
    logic [31:0]       r_res_rate, n_res_rate;
    logic              r_out_valid, n_out_valid;
    logic              r_out_new, n_out_new;
    logic [31:0]       r_out_rate, n_out_rate;

    logic [31:0]       rd_time;
    logic [31:0]       rd_bytes;
    logic              ram_we;
    logic [31:0]       wr_bytes;

    logic [64:0]       mod_prod;
    logic [AW-1:0]     mod_qn;
    logic [AW-1:0]     mod_rem;
    logic [RW1-1:0]    div_shift;
    logic              div_ge;
    logic [RW1-1:0]    div_diff;
    logic [32:0]       age_diff;
    logic              in_win;
    logic [AGE_W-1:0]  age_cand;
    logic              restart;
    logic [32:0]       add_sum;
    logic              out_free;

    // bucket stores
    wbrm_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (r_now),
        .i_raddr (r_addr),
        .o_rdata (rd_time)
    );

    wbrm_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_bytes_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wr_bytes),
        .i_raddr (r_addr),
        .o_rdata (rd_bytes)
    );

    // slot index: low quotient bits from the reciprocal product, then
    // remainder = now - q*SLOT_COUNT, which fits in the low AW bits
    assign mod_prod = {33'b0, i_now_seconds} * {32'b0, MOD_MUL};
    assign mod_qn   = AW'(r_qlo * AW'(SLOT_COUNT));
    assign mod_rem  = r_now[AW-1:0] - mod_qn;

    // divider step: shift in one dividend bit, trial subtract
    assign div_shift = {r_rem, r_dvd[DW-1]};
    assign div_ge    = div_shift >= RW1'(r_dvs);
    assign div_diff  = div_ge ? (div_shift - RW1'(r_dvs)) : div_shift;

    // window test for the bucket being walked
    assign age_diff = {1'b0, r_now} - {1'b0, rd_time};
    assign in_win   = r_valid[r_addr] && !age_diff[32] && (age_diff[31:0] != 32'd0)
                      && (age_diff[31:0] <= 32'(WINDOW_SECONDS));
    assign age_cand = AGE_W'(age_diff[31:0]);

    // add update with saturation
    assign restart  = !r_valid[r_addr] || (rd_time != r_now);
    assign add_sum  = (restart ? 33'd0 : {1'b0, rd_bytes}) + 33'(r_bytes);
    assign wr_bytes = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
    assign ram_we   = (r_state == S_ADD_WR);

    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_addr      = r_addr;
        n_qlo       = r_qlo;
        n_now       = r_now;
        n_bytes     = r_bytes;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_age       = r_age;
        n_res_new   = r_res_new;
        n_res_rate  = r_res_rate;
        n_out_valid = r_out_valid;
        n_out_new   = r_out_new;
        n_out_rate  = r_out_rate;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_now   = i_now_seconds;
                    n_bytes = i_byte_count;
                    if (i_req_type == REQ_ADD) begin
                        n_qlo   = mod_prod[MOD_SH +: AW];
                        n_state = S_MOD;
                    end else begin
                        n_addr  = '0;
                        n_total = '0;
                        n_age   = AGE_W'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_MOD: begin
                n_addr  = mod_rem;
                n_state = S_ADD_RD;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DW)) begin
                    n_res_new  = 1'b0;
                    n_res_rate = (r_dvd[DW-1:32] != '0) ? 32'hFFFF_FFFF : r_dvd[31:0];
                    n_state    = S_FIN;
                end else begin
                    n_dvd = {r_dvd[DW-2:0], div_ge};
                    n_rem = RW'(div_diff);
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_ADD_RD: begin
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                n_valid[r_addr] = 1'b1;
                n_res_new  = restart;
                n_res_rate = '0;
                n_state    = S_FIN;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_ACC;
            end
            S_SCAN_ACC: begin
                if (in_win) begin
                    n_total = r_total + DW'(rd_bytes);
                    if (age_cand > r_age) begin
                        n_age = age_cand;
                    end
                end
                if (r_addr == AW'(SLOT_COUNT - 1)) begin
                    n_state = S_SPAN;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SPAN: begin
                // span = age of oldest counted bucket minus one
                if (r_age == AGE_W'(1)) begin
                    n_res_new  = 1'b0;
                    n_res_rate = '0;
                    n_state    = S_FIN;
                end else begin
                    n_dvd   = r_total;
                    n_dvs   = D_W'(r_age - AGE_W'(1));
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_new   = r_res_new;
                    n_out_rate  = r_res_rate;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_qlo      <= n_qlo;
        r_now      <= n_now;
        r_bytes    <= n_bytes;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_cnt      <= n_cnt;
        r_total    <= n_total;
        r_age      <= n_age;
        r_res_new  <= n_res_new;
        r_res_rate <= n_res_rate;
        r_out_new  <= n_out_new;
        r_out_rate <= n_out_rate;
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_new_second         = r_out_new;
    assign o_rate_bytes_per_sec = r_out_rate;

    // an accepted beat always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but sequencer stayed idle");

    // divider never runs against a zero divisor and keeps its remainder reduced
    a_div_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0) && (r_rem < r_dvs))
        else $error("divider divisor or remainder out of range");

    // oldest-age tracker stays inside the window during the walk
    a_age_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_ACC) |-> (r_age != '0) && (r_age <= AGE_W'(WINDOW_SECONDS)))
        else $error("bucket age tracker outside window");

endmodule
